// ===== rtl/pfrf_pkg.sv =====
// ----------------------------------------------------------------------------
// pfrf_pkg: shared types and constants for the page framebuffer fill block
// Byte and rectangle types, item kinds, sequencer states and default sizes.
// ----------------------------------------------------------------------------
package pfrf_pkg;

  localparam int DEF_COLUMNS = 128;
  localparam int DEF_PAGES   = 8;

  localparam int BYTE_W    = 8;
  localparam int PAGE_ROWS = 8;
  localparam int ROW_SHIFT = 3;

  typedef logic [BYTE_W-1:0] byte_t;

  localparam byte_t BYTE_ALL = 8'hFF;

  typedef enum logic {
    KIND_FILL = 1'b0,
    KIND_READ = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_READ,
    S_FRD,
    S_FWR
  } state_e;

  // Rows covered by the fill that is in progress, and its ink.
  typedef struct packed {
    logic [5:0] top;
    logic [6:0] last_row;
    logic       ink;
  } rect_t;

endpackage

// ===== rtl/pfrf_store.sv =====
// ----------------------------------------------------------------------------
// pfrf_store: framebuffer byte memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pfrf_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  pfrf_pkg::byte_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output pfrf_pkg::byte_t rdata_o
);
  import pfrf_pkg::*;

  byte_t mem [DEPTH];
  byte_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/pfrf_mask.sv =====
// ----------------------------------------------------------------------------
// pfrf_mask: page mask and byte merge unit
// Builds the row mask of one page from the fill rows and merges the ink into
// a byte read from the store.
// ----------------------------------------------------------------------------
module pfrf_mask #(
  parameter int PW = 3
) (
  input  logic [PW-1:0]   page_i,
  input  pfrf_pkg::rect_t rect_i,
  input  pfrf_pkg::byte_t data_i,
  output pfrf_pkg::byte_t data_o
);
  import pfrf_pkg::*;

  logic [7:0] base;
  logic [7:0] first;
  logic [7:0] last;
  logic [2:0] lo;
  logic [2:0] hi;
  byte_t      mask;

  // The sequencer only visits pages between the first and last row, so both
  // differences below stay within one page.
  always_comb begin
    base  = 8'(page_i) * 8'(PAGE_ROWS);
    first = 8'(rect_i.top);
    last  = 8'(rect_i.last_row);
    lo    = (first > base) ? 3'(first - base) : 3'd0;
    hi    = (last < (base + 8'd7)) ? 3'(last - base) : 3'd7;
    mask  = (BYTE_ALL << lo) & (BYTE_ALL >> (3'd7 - hi));
    if (rect_i.ink) begin
      data_o = data_i | mask;
    end else begin
      data_o = data_i & ~mask;
    end
  end

endmodule

// ===== rtl/page_framebuffer_rect_fill_core.sv =====
// ----------------------------------------------------------------------------
// page_framebuffer_rect_fill_core: monochrome page framebuffer with fill
// Holds COLUMNS x PAGES bytes of 8 vertical pixels and fills rectangles into
// them by read-modify-write, or reads back one byte.
//
//   Channel  Ports                                         Handshake
//   item     kind_i left_column_i top_row_i extra_columns_i start / busy
//            extra_rows_i ink_i read_page_i
//   result   read_data_o                                   done_o strobe
//
// A read passes through S_READ; its done_o strobe and byte are then registered.
// A fill visits each byte it touches in S_FRD (one store read) and S_FWR (one
// store write); with nothing in range the result comes in the cycle after the
// transfer. After reset the store is cleared one byte a cycle, all COLUMNS*PAGES
// bytes (1024 by default), with busy high.
// done_o is high for one cycle only; read_data_o holds the result until the next.
// The receiver cannot stall, and a new item may be transferred in the strobe cycle.
// ----------------------------------------------------------------------------
module page_framebuffer_rect_fill_core #(
  parameter int COLUMNS = pfrf_pkg::DEF_COLUMNS,
  parameter int PAGES   = pfrf_pkg::DEF_PAGES
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  logic            kind_i,
  input  logic [6:0]      left_column_i,
  input  logic [5:0]      top_row_i,
  input  logic [6:0]      extra_columns_i,
  input  logic [5:0]      extra_rows_i,
  input  logic            ink_i,
  input  logic [2:0]      read_page_i,
  output logic            done_o,
  output pfrf_pkg::byte_t read_data_o
);
  import pfrf_pkg::*;

  localparam int DEPTH = COLUMNS * PAGES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(COLUMNS);
  localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;

  localparam logic [8:0]    COLS_LIM  = 9'(COLUMNS);
  localparam logic [8:0]    COL_MAX   = 9'(COLUMNS - 1);
  localparam logic [4:0]    PAGES_LIM = 5'(PAGES);
  localparam logic [4:0]    PAGE_MAX  = 5'(PAGES - 1);
  localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);

  state_e        state_q, state_d;
  logic [AW-1:0] clr_q, clr_d;
  logic [CW-1:0] col_q, col_d;
  logic [CW-1:0] left_q, left_d;
  logic [CW-1:0] col_end_q, col_end_d;
  logic [PW-1:0] page_q, page_d;
  logic [PW-1:0] page_end_q, page_end_d;
  rect_t         rect_q, rect_d;
  logic          in_range_q, in_range_d;
  logic          done_q, done_d;
  byte_t         rdata_q, rdata_d;

  logic          accept;
  logic [8:0]    col_sum;
  logic [6:0]    last_row;
  logic [4:0]    top_page;
  logic [4:0]    last_page;
  logic [AW-1:0] fill_addr;
  logic [AW-1:0] read_addr;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  byte_t         mem_wdata;
  logic [AW-1:0] mem_raddr;
  byte_t         mem_rdata;
  byte_t         merged;

  pfrf_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  pfrf_mask #(
    .PW (PW)
  ) u_mask (
    .page_i (page_q),
    .rect_i (rect_q),
    .data_i (mem_rdata),
    .data_o (merged)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  assign col_sum   = 9'(left_column_i) + 9'(extra_columns_i);
  assign last_row  = 7'(top_row_i) + 7'(extra_rows_i);
  assign top_page  = 5'(top_row_i >> ROW_SHIFT);
  assign last_page = 5'(last_row >> ROW_SHIFT);
  assign fill_addr = AW'(col_q) * AW'(PAGES) + AW'(page_q);
  assign read_addr = AW'(left_column_i) * AW'(PAGES) + AW'(read_page_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_CLEAR;
      clr_q      <= '0;
      col_q      <= '0;
      left_q     <= '0;
      col_end_q  <= '0;
      page_q     <= '0;
      page_end_q <= '0;
      in_range_q <= 1'b0;
      done_q     <= 1'b0;
      rdata_q    <= '0;
    end else begin
      state_q    <= state_d;
      clr_q      <= clr_d;
      col_q      <= col_d;
      left_q     <= left_d;
      col_end_q  <= col_end_d;
      page_q     <= page_d;
      page_end_q <= page_end_d;
      in_range_q <= in_range_d;
      done_q     <= done_d;
      rdata_q    <= rdata_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rect_q <= rect_d;
  end

  always_comb begin
    state_d    = state_q;
    clr_d      = clr_q;
    col_d      = col_q;
    left_d     = left_q;
    col_end_d  = col_end_q;
    page_d     = page_q;
    page_end_d = page_end_q;
    rect_d     = rect_q;
    in_range_d = in_range_q;
    done_d     = 1'b0;
    rdata_d    = rdata_q;
    mem_we     = 1'b0;
    mem_waddr  = fill_addr;
    mem_wdata  = merged;
    mem_raddr  = fill_addr;

    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == ADDR_LAST) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = read_addr;
        if (accept) begin
          if (kind_i == KIND_READ) begin
            in_range_d = ({2'b00, left_column_i} < COLS_LIM) &&
                         (5'(read_page_i) < PAGES_LIM);
            state_d    = S_READ;
          end else begin
            left_d     = CW'(left_column_i);
            col_d      = CW'(left_column_i);
            page_d     = PW'(top_page);
            col_end_d  = (col_sum > COL_MAX) ? CW'(COL_MAX) : CW'(col_sum);
            page_end_d = (last_page > PAGE_MAX) ? PW'(PAGE_MAX) : PW'(last_page);
            rect_d     = '{top: top_row_i, last_row: last_row, ink: ink_i};
            if (({2'b00, left_column_i} < COLS_LIM) && (top_page < PAGES_LIM)) begin
              state_d = S_FRD;
            end else begin
              // The whole rectangle lies off the screen.
              done_d  = 1'b1;
              rdata_d = '0;
            end
          end
        end
      end
      S_READ: begin
        done_d  = 1'b1;
        rdata_d = in_range_q ? mem_rdata : '0;
        state_d = S_IDLE;
      end
      S_FRD: begin
        state_d = S_FWR;
      end
      S_FWR: begin
        mem_we = 1'b1;
        if (col_q == col_end_q) begin
          col_d = left_q;
          if (page_q == page_end_q) begin
            done_d  = 1'b1;
            rdata_d = '0;
            state_d = S_IDLE;
          end else begin
            page_d  = page_q + 1'b1;
            state_d = S_FRD;
          end
        end else begin
          col_d   = col_q + 1'b1;
          state_d = S_FRD;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign done_o      = done_q;
  assign read_data_o = rdata_q;

  // The fill walk never steps past its clamped last column or last page.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FRD) |-> ((col_q <= col_end_q) && (page_q <= page_end_q)))
    else $error("fill walk left its clamped column or page range");

  // A read item delivers its byte via the S_READ state and the done_o register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (kind_i == KIND_READ)) |-> ##2 done_o)
    else $error("read result not delivered two cycles after transfer");

  // Once the clearing pass is over, busy only rises on a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a transfer");

endmodule
